FILE: rtl/b62e_pkg.sv
// ----------------------------------------------------------------------------
// b62e_pkg
// Shared types, constants and the digit-to-ASCII map for the base-62 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b62e_pkg;

  // width of the input value and of one base-62 digit
  localparam int NUM_W          = 64;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int MIN_LEN_W      = 5;

  // 62^11 exceeds 2^63, so eleven digits always suffice
  localparam int NUM_DIGITS     = 11;
  localparam int DIGIT_IDX_W    = $clog2(NUM_DIGITS);

  // conversion pipeline: four input bits folded in per stage
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_STAGES     = NUM_W / BITS_PER_STAGE;

  localparam int RADIX          = 62;
  localparam int HALF_RADIX     = RADIX / 2;

  // default for the top-level length parameter
  localparam int MAX_LEN_DEF    = 16;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // one conversion pipeline slot
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [NUM_W-1:0] bits;
    digits_t          digits;
  } stage_t;

  // digit value to alphabet character: 0-9, A-Z, a-z
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DIGIT_W'(10)) begin
      digit_char = CHAR_W'(7'h30) + dx;
    end else if (d < DIGIT_W'(36)) begin
      digit_char = CHAR_W'(7'h41) + dx - CHAR_W'(10);
    end else begin
      digit_char = CHAR_W'(7'h61) + dx - CHAR_W'(36);
    end
  endfunction

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;

endpackage

`default_nettype wire

FILE: rtl/b62e_cvt_stage.sv
// ----------------------------------------------------------------------------
// b62e_cvt_stage
// One conversion stage: shifts four input bits into the base-62 digit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module b62e_cvt_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire b62e_pkg::stage_t d,
  output b62e_pkg::stage_t     q
);

  b62e_pkg::stage_t nxt;

  // digit vector doubled plus incoming bit; a digit of 31 or more always
  // carries out, so all carries are known before the add
  always_comb begin
    logic [b62e_pkg::NUM_DIGITS:0]  carry;
    logic [b62e_pkg::DIGIT_W:0]     tmp;
    nxt = d;
    for (int j = 0; j < b62e_pkg::BITS_PER_STAGE; j++) begin
      carry[0] = nxt.bits[b62e_pkg::NUM_W-1];
      for (int i = 0; i < b62e_pkg::NUM_DIGITS; i++) begin
        carry[i+1] = (nxt.digits[i] >= b62e_pkg::DIGIT_W'(b62e_pkg::HALF_RADIX));
      end
      for (int i = 0; i < b62e_pkg::NUM_DIGITS; i++) begin
        tmp = {nxt.digits[i], carry[i]};
        if (carry[i+1]) begin
          tmp = tmp - (b62e_pkg::DIGIT_W+1)'(b62e_pkg::RADIX);
        end
        nxt.digits[i] = tmp[b62e_pkg::DIGIT_W-1:0];
      end
      nxt.bits = {nxt.bits[b62e_pkg::NUM_W-2:0], 1'b0};
    end
  end

  // stage register, only valid is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
    if (en) begin
      q.neg    <= nxt.neg;
      q.bits   <= nxt.bits;
      q.digits <= nxt.digits;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b62e_serializer.sv
// ----------------------------------------------------------------------------
// b62e_serializer
// Takes a converted digit vector and emits its characters, most significant
// first, left padded, last one marked; a negative gets one error character.
// ----------------------------------------------------------------------------
`default_nettype none

module b62e_serializer #(
  parameter int MAX_LEN = b62e_pkg::MAX_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire b62e_pkg::stage_t               item,
  input  wire logic [b62e_pkg::MIN_LEN_W-1:0] min_length,
  output logic                                load_ok,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [b62e_pkg::CHAR_W-1:0]         text_char,
  output logic                                last_char,
  output logic                                negative_error
);

  localparam int LW = $clog2(MAX_LEN + 1);

  logic                    busy;
  logic                    neg;
  logic [LW-1:0]           rem;
  b62e_pkg::digits_t       digits;

  logic [LW-1:0]           ndig;
  logic [LW-1:0]           tgt;
  logic [LW-1:0]           total;
  logic                    emit;
  logic                    load;
  logic [b62e_pkg::CHAR_W-1:0] ch;

  assign load_ok = !busy;
  assign load    = load_ok && item.valid;
  assign emit    = busy && (!out_valid || out_ready);

  // significant digit count and run length
  always_comb begin
    ndig = '0;
    for (int i = 0; i < b62e_pkg::NUM_DIGITS; i++) begin
      if (item.digits[i] != '0) begin
        ndig = LW'(i + 1);
      end
    end
    if (int'(min_length) > MAX_LEN) begin
      tgt = LW'(MAX_LEN);
    end else begin
      tgt = LW'(min_length);
    end
    total = (ndig > tgt) ? ndig : tgt;
  end

  // character at the current position, padding above the stored digits
  always_comb begin
    if (rem < LW'(b62e_pkg::NUM_DIGITS)) begin
      ch = b62e_pkg::digit_char(digits[rem[b62e_pkg::DIGIT_IDX_W-1:0]]);
    end else begin
      ch = b62e_pkg::CHAR_ZERO;
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= item.neg || (total != '0);
    end else if (emit && (neg || rem == '0)) begin
      busy <= 1'b0;
    end
    if (load) begin
      neg    <= item.neg;
      rem    <= total - LW'(1);
      digits <= item.digits;
    end else if (emit) begin
      rem <= rem - LW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      text_char      <= neg ? '0 : ch;
      last_char      <= neg || (rem == '0);
      negative_error <= neg;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/base62_integer_encoder_unit.sv
// ----------------------------------------------------------------------------
// base62_integer_encoder_unit
// Encodes a signed 64-bit value as base-62 ASCII text, one character per
// output transaction, most significant first, left padded to min_length.
// ----------------------------------------------------------------------------
//  channel  signals                                     direction
//  in       in_valid, in_ready, number                  to block
//  out      out_valid, out_ready, text_char,
//           last_char, negative_error                   from block
//  cfg      cfg_wen, cfg_wdata (min_length)             to block
//
//  A value passes a 16-stage conversion pipeline (4 bits per stage), then
//  the serializer loads it and sends one character per cycle unless out
//  stalls: max(digits, min_length) characters, one error character for a
//  negative value, none when the run is empty. It loads a value only once
//  the last one is sent and so sets the sustained rate; the pipeline holds
//  up to 16 values behind it. A stall on out freezes the serializer and then
//  the pipeline, losing nothing. Reset clears all valid bits and min_length.
// ----------------------------------------------------------------------------
`default_nettype none

module base62_integer_encoder_unit #(
  parameter int MAX_LEN = b62e_pkg::MAX_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [b62e_pkg::NUM_W-1:0] number,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [b62e_pkg::CHAR_W-1:0]            text_char,
  output logic                                   last_char,
  output logic                                   negative_error,
  input  wire logic                              cfg_wen,
  input  wire logic [b62e_pkg::MIN_LEN_W-1:0]    cfg_wdata
);

  logic [b62e_pkg::MIN_LEN_W-1:0] min_length;
  b62e_pkg::stage_t               pipe [b62e_pkg::NUM_STAGES+1];
  logic                           load_ok;
  logic                           en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_wen) begin
      min_length <= cfg_wdata;
    end
  end

  // pipeline moves whenever its tail can drain
  assign en       = !pipe[b62e_pkg::NUM_STAGES].valid || load_ok;
  assign in_ready = en;

  // pipeline entry, digits start at zero
  always_comb begin
    pipe[0].valid  = in_valid;
    pipe[0].neg    = number[b62e_pkg::NUM_W-1];
    pipe[0].bits   = number;
    pipe[0].digits = '0;
  end

  // conversion stages
  for (genvar s = 0; s < b62e_pkg::NUM_STAGES; s++) begin : g_stage
    b62e_cvt_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (pipe[s]),
      .q   (pipe[s+1])
    );
  end

  // character output
  b62e_serializer #(
    .MAX_LEN (MAX_LEN)
  ) u_ser (
    .clk            (clk),
    .rst            (rst),
    .item           (pipe[b62e_pkg::NUM_STAGES]),
    .min_length     (min_length),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .text_char      (text_char),
    .last_char      (last_char),
    .negative_error (negative_error)
  );

endmodule

`default_nettype wire

FILE: verif/tb_base62_integer_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_base62_integer_encoder_unit
// Drives signed 64-bit values into the base-62 encoder across several
// min_length settings, including zero and saturated lengths. A built-in
// predictor expands every accepted value into its character run. Every
// output transaction is checked in order against that run. Both channels
// idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base62_integer_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_W        = b62e_pkg::NUM_W;
  localparam int          CHAR_W       = b62e_pkg::CHAR_W;
  localparam int          MIN_LEN_W    = b62e_pkg::MIN_LEN_W;
  localparam int          MAX_LEN      = b62e_pkg::MAX_LEN_DEF;
  localparam logic [63:0] B62          = 64'd62;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          MAX_WAIT     = 18;
  localparam int          ITEMS_PER_PHASE = 17;

  // alphabet, first character in the top byte
  localparam logic [62*8-1:0] ALPHABET =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } text_result_t;

  typedef struct {
    logic signed [NUM_W-1:0] value;
    bit                      hold;
  } pending_number_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [NUM_W-1:0]  number = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CHAR_W-1:0]        text_char;
  logic                     last_char;
  logic                     negative_error;
  logic                     cfg_wen = 1'b0;
  logic [MIN_LEN_W-1:0]     cfg_wdata = '0;

  pending_number_t          pending_numbers[$];
  text_result_t             expected_chars[$];
  logic [MIN_LEN_W-1:0]     min_len_setting = '0;
  logic                     drained = 1'b1;
  bit                       tx_steady = 1'b0;
  bit                       rx_steady = 1'b0;
  int                       send_wait = 0;
  int                       stall_wait = 0;
  int                       idle_cycles = 0;
  int                       errors = 0;
  int                       result_count = 0;
  int                       rx_draw;
  text_result_t             want;

  base62_integer_encoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .number         (number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .text_char      (text_char),
    .last_char      (last_char),
    .negative_error (negative_error),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  // expand one value into the characters it should produce
  function automatic void predict_run(input logic signed [NUM_W-1:0] value);
    logic [NUM_W-1:0] rest;
    logic [5:0]       digs [0:MAX_LEN-1];
    int               ndig;
    int               target;
    int               total;
    int               pos;
    text_result_t     r;
    if (value[NUM_W-1]) begin
      r.ch = '0;
      r.last = 1'b1;
      r.err = 1'b1;
      expected_chars.push_back(r);
      return;
    end
    rest = value;
    ndig = 0;
    while (rest != 0) begin
      digs[ndig] = 6'(rest % B62);
      rest = rest / B62;
      ndig++;
    end
    target = (min_len_setting > MAX_LEN) ? MAX_LEN : int'(min_len_setting);
    total = (ndig > target) ? ndig : target;
    if (total > MAX_LEN) total = MAX_LEN;
    for (int k = 0; k < total; k++) begin
      pos = total - 1 - k;
      if (pos < ndig) r.ch = ALPHABET[(61 - int'(digs[pos])) * 8 +: CHAR_W];
      else r.ch = CHAR_W'("0");
      r.last = (k == total - 1);
      r.err = 1'b0;
      expected_chars.push_back(r);
    end
  endfunction

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // mostly positive values of random width, some negative, some zero
  function automatic logic signed [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] raw;
    int               pick;
    raw = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 3) return raw | {1'b1, {(NUM_W-1){1'b0}}};
    else if (pick == 3) return '0;
    else if (pick == 4) return {1'b0, {(NUM_W-1){1'b1}}};
    else return {1'b0, raw[NUM_W-2:0]} >> $urandom_range(0, NUM_W - 2);
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint exp_val);
    $display("mismatch at result %0d: %s got %0h expected %0h",
             result_count, what, got, exp_val);
    errors++;
  endtask

  task automatic push_number(input logic signed [NUM_W-1:0] value, input bit hold);
    pending_number_t p;
    p.value = value;
    p.hold = hold;
    pending_numbers.push_back(p);
  endtask

  // wait for the block to go quiet, then let the pipeline flush
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_length(input logic [MIN_LEN_W-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
    min_len_setting = value;
  endtask

  // input driver: next value goes out once the slot frees and the gap ends;
  // a held value also waits until nothing is on the wire and all results came
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_numbers.size() != 0 &&
                   (!pending_numbers[0].hold || (!in_valid && drained))) begin
        in_valid <= 1'b1;
        number <= pending_numbers[0].value;
        pending_numbers.pop_front();
        send_wait <= draw_wait(tx_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stalls: ready drops for a drawn number of cycles after each transaction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_wait <= 0;
    end else if (out_valid && out_ready) begin
      rx_draw = draw_wait(rx_steady);
      stall_wait <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (stall_wait != 0) begin
      stall_wait <= stall_wait - 1;
      out_ready <= (stall_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (rst) begin
      drained <= 1'b1;
    end else begin
      if (in_valid && in_ready) predict_run(number);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected text_char", text_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (text_char !== want.ch) report_mismatch("text_char", text_char, want.ch);
          if (last_char !== want.last) report_mismatch("last_char", last_char, want.last);
          if (negative_error !== want.err)
            report_mismatch("negative_error", negative_error, want.err);
        end
        result_count++;
      end
      drained <= (expected_chars.size() == 0);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_base62_integer_encoder_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    logic [NUM_W-1:0]     pow10;
    logic [MIN_LEN_W-1:0] settings [0:7];
    int                   hold_at;

    settings = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd11, 5'd17, 5'd5, 5'd0};
    pow10 = 64'd1;
    repeat (10) pow10 = pow10 * B62;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // edge values at the reset length of zero
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    push_number(64'sd0, 1'b0);
    push_number(64'sd1, 1'b0);
    push_number(64'sd9, 1'b0);
    push_number(64'sd10, 1'b0);
    push_number(64'sd35, 1'b0);
    push_number(64'sd36, 1'b0);
    push_number(64'sd61, 1'b0);
    push_number(64'sd62, 1'b0);
    push_number(64'sd3843, 1'b0);
    push_number(pow10 - 64'd1, 1'b0);
    push_number(pow10, 1'b0);
    push_number({1'b0, {(NUM_W-1){1'b1}}}, 1'b0);
    push_number(-64'sd1, 1'b0);
    push_number({1'b1, {(NUM_W-1){1'b0}}}, 1'b0);
    push_number(64'sd0, 1'b0);
    wait_idle();

    // one phase per length setting, padding and saturation included
    for (int p = 0; p < 8; p++) begin
      write_min_length(p == 7 ? MIN_LEN_W'($urandom_range(0, 31)) : settings[p]);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      hold_at = $urandom_range(4, ITEMS_PER_PHASE - 1);
      push_number(64'sd0, 1'b0);
      push_number({1'b0, {(NUM_W-1){1'b1}}}, 1'b0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_number(random_number(), i == hold_at);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_base62_integer_encoder_unit passed");
    end else begin
      $display("tb_base62_integer_encoder_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
